// ===== rtl/lpl_pkg.sv =====
`default_nettype none

package lpl_pkg;

    // Field widths fixed by the frame format
    localparam int SAMPLE_BITS    = 24;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int GAIN_BITS      = GAIN_FRAC_BITS + 1;
    localparam int CEIL_BITS      = 23;
    localparam int COEFF_BITS     = 16;
    localparam int DLEN_BITS      = 8;
    localparam int CHAN_BITS      = 2;
    localparam int PADDR_BITS     = 4;
    localparam int PDATA_BITS     = 32;

    // Shared multiplier: signed sample (or zero-extended coefficient) times gain
    localparam int MUL_A_BITS = SAMPLE_BITS + 1;
    localparam int MUL_B_BITS = GAIN_BITS + 1;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [GAIN_BITS-1:0]  GAIN_UNITY = GAIN_BITS'(1) << GAIN_FRAC_BITS;
    localparam logic [PROD_BITS-1:0]  ROUND_BIAS = PROD_BITS'(1) << (GAIN_FRAC_BITS - 1);

    localparam logic [CEIL_BITS-1:0]  CEIL_RESET  = 23'd8388607;
    localparam logic [COEFF_BITS-1:0] COEFF_RESET = 16'd65427;
    localparam logic [DLEN_BITS-1:0]  DLEN_RESET  = 8'd0;
    localparam logic [CHAN_BITS-1:0]  CHAN_RESET  = 2'd2;

    typedef logic signed [SAMPLE_BITS-1:0] lpl_sample_t;
    typedef logic [SAMPLE_BITS-1:0]        lpl_mag_t;
    typedef logic [GAIN_BITS-1:0]          lpl_gain_t;

    typedef enum logic [1:0] {
        REG_CEILING = 2'd0,
        REG_COEFF   = 2'd1,
        REG_DELAY   = 2'd2,
        REG_CHANNEL = 2'd3
    } lpl_reg_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_PEAK,
        F_DIV,
        F_PUSH
    } lpl_front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ENV_A,
        B_ENV_B,
        B_ENV_C,
        B_APPLY0,
        B_APPLY1,
        B_FINISH
    } lpl_back_state_t;

    typedef struct packed {
        lpl_sample_t sample_ch0;
        lpl_sample_t sample_ch1;
        logic        block_last;
    } lpl_in_t;

    typedef struct packed {
        lpl_sample_t out_ch0;
        lpl_sample_t out_ch1;
        lpl_gain_t   applied_gain;
        logic        block_last_out;
    } lpl_out_t;

    // Classified frame handed from the front to the back
    typedef struct packed {
        lpl_sample_t sample_ch0;
        lpl_sample_t sample_ch1;
        logic        block_last;
        lpl_gain_t   target;
    } lpl_job_t;

    typedef struct packed {
        logic [CEIL_BITS-1:0]  ceiling_level;
        logic [COEFF_BITS-1:0] release_coeff;
        logic [DLEN_BITS-1:0]  delay_length;
        logic                  stereo;
        logic                  clear;
    } lpl_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/lpl_stream_if.sv =====
`default_nettype none

interface lpl_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/lpl_ram.sv =====
`default_nettype none

module lpl_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/lpl_front.sv =====
`default_nettype none

module lpl_front
    import lpl_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire lpl_cfg_t cfg,
    lpl_stream_if.sink    in_frame,
    lpl_stream_if.source  job
);

    localparam int STEP_BITS = $clog2(GAIN_FRAC_BITS);

    lpl_front_state_t state_reg, state_next;

    lpl_sample_t                s0_reg, s1_reg;
    logic                       last_reg;
    lpl_mag_t                   rem_reg, div_reg;
    logic [GAIN_FRAC_BITS-1:0]  quo_reg;
    logic [STEP_BITS-1:0]       cnt_reg;
    lpl_gain_t                  target_reg;

    lpl_mag_t                   abs0, abs1, peak;
    logic                       over;
    logic [SAMPLE_BITS:0]       shifted, diff;
    logic                       ge;
    lpl_mag_t                   rem_next;
    logic [GAIN_FRAC_BITS-1:0]  quo_next;
    logic                       last_step;

    // Peak magnitude over the active channels
    always_comb
    begin
        abs0 = s0_reg[SAMPLE_BITS-1] ? lpl_mag_t'(~s0_reg + 1'b1) : lpl_mag_t'(s0_reg);
        abs1 = s1_reg[SAMPLE_BITS-1] ? lpl_mag_t'(~s1_reg + 1'b1) : lpl_mag_t'(s1_reg);
        peak = (cfg.stereo && (abs1 > abs0)) ? abs1 : abs0;
        over = peak > lpl_mag_t'(cfg.ceiling_level);
    end

    // One restoring divide step; the remainder always stays below the peak
    always_comb
    begin
        shifted   = {rem_reg, 1'b0};
        diff      = shifted - {1'b0, div_reg};
        ge        = shifted >= {1'b0, div_reg};
        rem_next  = ge ? diff[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
        quo_next  = {quo_reg[GAIN_FRAC_BITS-2:0], ge};
        last_step = cnt_reg == STEP_BITS'(GAIN_FRAC_BITS - 1);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_frame.valid)
                begin
                    state_next = F_PEAK;
                end
            end
            F_PEAK:
            begin
                state_next = over ? F_DIV : F_PUSH;
            end
            F_DIV:
            begin
                if (last_step)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (job.ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_frame.ready             = state_reg == F_IDLE;
        job.valid                  = state_reg == F_PUSH;
        job.payload.sample_ch0     = s0_reg;
        job.payload.sample_ch1     = cfg.stereo ? s1_reg : '0;
        job.payload.block_last     = last_reg;
        job.payload.target         = target_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                s0_reg   <= in_frame.payload.sample_ch0;
                s1_reg   <= in_frame.payload.sample_ch1;
                last_reg <= in_frame.payload.block_last;
            end
            F_PEAK:
            begin
                rem_reg    <= lpl_mag_t'(cfg.ceiling_level);
                div_reg    <= peak;
                quo_reg    <= '0;
                cnt_reg    <= '0;
                target_reg <= GAIN_UNITY;
            end
            F_DIV:
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    target_reg <= {1'b0, quo_next};
                end
            end
            default:
            begin
            end
        endcase
    end

    a_rem_below_peak: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_DIV) |-> (rem_reg < div_reg))
        else $error("divider remainder reached the peak");

endmodule

`default_nettype wire

// ===== rtl/lpl_queue.sv =====
`default_nettype none

module lpl_queue
    import lpl_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    lpl_stream_if.sink   push,
    lpl_stream_if.source pop
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    lpl_job_t         entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push, do_pop;

    always_comb
    begin
        push.ready  = count_reg != CW'(QUEUE_DEPTH);
        pop.valid   = count_reg != '0;
        pop.payload = entry_reg[rd_ptr_reg];
        do_push     = push.valid && push.ready;
        do_pop      = pop.valid && pop.ready;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

endmodule

`default_nettype wire

// ===== rtl/lpl_back.sv =====
`default_nettype none

module lpl_back
    import lpl_pkg::*;
#(
    parameter int DELAY_DEPTH = 256
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire lpl_cfg_t cfg,
    lpl_stream_if.sink    job,
    lpl_stream_if.source  out_frame
);

    localparam int AW      = $clog2(DELAY_DEPTH);
    localparam int MAX_LEN = DELAY_DEPTH - 1;

    lpl_back_state_t state_reg, state_next;

    lpl_job_t                      job_reg;
    lpl_gain_t                     gain_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic [PROD_BITS-1:0]          acc_reg;
    logic                          drop_reg;
    logic [AW-1:0]                 wi_reg, fill_reg;
    logic                          hit_reg;
    lpl_sample_t                   samp1_reg, res0_reg;
    lpl_out_t                      out_reg;
    logic                          out_valid_reg;

    logic [AW-1:0]                 len, wi_wrap, raddr;
    logic                          delay_on;
    logic signed [MUL_A_BITS-1:0]  mul_a;
    logic signed [MUL_B_BITS-1:0]  mul_b;
    logic signed [PROD_BITS-1:0]   prod_next;
    logic [PROD_BITS-1:0]          sum, rnd;
    lpl_sample_t                   rounded, sel0, sel1;
    lpl_gain_t                     gain_next;
    logic                          ram_we, ram_re, out_free, load_out;
    logic [2*SAMPLE_BITS-1:0]      ram_rdata;

    // Look-ahead length, limited to the ring size
    always_comb
    begin
        if (int'(cfg.delay_length) > MAX_LEN)
        begin
            len = AW'(MAX_LEN);
        end
        else
        begin
            len = AW'(cfg.delay_length);
        end
        delay_on = len != '0;
        wi_wrap  = (wi_reg == len) ? '0 : wi_reg + 1'b1;
        raddr    = wi_wrap;
    end

    // Entries not yet written since the last clear read as zero
    always_comb
    begin
        sel0 = delay_on ? (hit_reg ? $signed(ram_rdata[SAMPLE_BITS-1:0]) : '0)
                        : job_reg.sample_ch0;
        sel1 = delay_on ? (hit_reg ? $signed(ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]) : '0)
                        : job_reg.sample_ch1;
    end

    // Attack takes the target; release: coeff*gain + (unity-coeff)*target, truncated
    always_comb
    begin
        sum       = acc_reg + prod_reg;
        gain_next = drop_reg ? job_reg.target : sum[GAIN_FRAC_BITS +: GAIN_BITS];
        rnd       = prod_reg + ROUND_BIAS;
        rounded   = $signed(rnd[GAIN_FRAC_BITS +: SAMPLE_BITS]);
        out_free  = !out_valid_reg || out_frame.ready;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (job.valid)
                begin
                    state_next = B_ENV_A;
                end
            end
            B_ENV_A:  state_next = B_ENV_B;
            B_ENV_B:  state_next = B_ENV_C;
            B_ENV_C:  state_next = B_APPLY0;
            B_APPLY0: state_next = B_APPLY1;
            B_APPLY1: state_next = B_FINISH;
            B_FINISH:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:  state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        job.ready = state_reg == B_IDLE;
        mul_a     = '0;
        mul_b     = '0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            B_ENV_A:
            begin
                mul_a = $signed(MUL_A_BITS'(cfg.release_coeff));
                mul_b = $signed(MUL_B_BITS'(gain_reg));
            end
            B_ENV_B:
            begin
                mul_a = $signed(MUL_A_BITS'(GAIN_UNITY - GAIN_BITS'(cfg.release_coeff)));
                mul_b = $signed(MUL_B_BITS'(job_reg.target));
            end
            B_ENV_C:
            begin
                ram_we = delay_on;
                ram_re = 1'b1;
            end
            B_APPLY0:
            begin
                mul_a = MUL_A_BITS'(sel0);
                mul_b = $signed(MUL_B_BITS'(gain_reg));
            end
            B_APPLY1:
            begin
                mul_a = MUL_A_BITS'(samp1_reg);
                mul_b = $signed(MUL_B_BITS'(gain_reg));
            end
            B_FINISH:
            begin
                load_out = out_free;
            end
            default:
            begin
            end
        endcase
        prod_next = mul_a * mul_b;
        out_frame.valid   = out_valid_reg;
        out_frame.payload = out_reg;
    end

    lpl_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (DELAY_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wi_reg),
        .wdata ({job_reg.sample_ch1, job_reg.sample_ch0}),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            gain_reg      <= GAIN_UNITY;
            wi_reg        <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_ENV_C)
            begin
                gain_reg <= gain_next;
            end
            if (cfg.clear)
            begin
                wi_reg   <= '0;
                fill_reg <= '0;
            end
            else if (ram_we)
            begin
                wi_reg   <= wi_wrap;
                fill_reg <= (fill_reg == len) ? fill_reg : fill_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_frame.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job.valid && job.ready)
        begin
            job_reg <= job.payload;
        end
        if (state_reg == B_ENV_A)
        begin
            drop_reg <= job_reg.target < gain_reg;
        end
        if (state_reg == B_ENV_B)
        begin
            acc_reg <= prod_reg;
        end
        if (state_reg == B_ENV_C)
        begin
            hit_reg <= fill_reg == len;
        end
        if (state_reg == B_APPLY0)
        begin
            samp1_reg <= sel1;
        end
        if (state_reg == B_APPLY1)
        begin
            res0_reg <= rounded;
        end
        if (state_reg == B_ENV_A || state_reg == B_ENV_B ||
            state_reg == B_APPLY0 || state_reg == B_APPLY1)
        begin
            prod_reg <= prod_next;
        end
        if (load_out)
        begin
            out_reg.out_ch0        <= res0_reg;
            out_reg.out_ch1        <= cfg.stereo ? rounded : '0;
            out_reg.applied_gain   <= gain_reg;
            out_reg.block_last_out <= job_reg.block_last;
        end
    end

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg <= GAIN_UNITY)
        else $error("gain envelope above unity");

    a_ring_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (wi_reg <= len) && (fill_reg <= len))
        else $error("ring pointer or fill count past look-ahead length");

endmodule

`default_nettype wire

// ===== rtl/lookahead_peak_limiter_top.sv =====
`default_nettype none

// Channel     Dir  Handshake         Payload
// in_frame    in   valid/ready       sample_ch0, sample_ch1, block_last
// out_frame   out  valid/ready       out_ch0, out_ch1, applied_gain, block_last_out
// apb         in   psel/penable      paddr[3:2] selects the register, pwdata 32 bits
//
// Front: a peak check per request, plus the 16-step restoring divider when the peak
// is above the ceiling; the divider, when it runs, sets the sustained rate.
// Back: envelope and apply steps on one shared 25x18 multiplier and the delay RAM.
// A 2-entry queue between them and the output register let each side stall alone.
// Reset clears control, the gain envelope (unity) and the ring; no clearing pass.

module lookahead_peak_limiter_top
    import lpl_pkg::*;
#(
    parameter int DELAY_DEPTH = 256
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    lpl_stream_if.sink                 in_frame,
    lpl_stream_if.source               out_frame,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_BITS-1:0] paddr,
    input  wire logic [PDATA_BITS-1:0] pwdata,
    output logic      [PDATA_BITS-1:0] prdata,
    output logic                       pready
);

    logic [CEIL_BITS-1:0]  ceiling_reg;
    logic [COEFF_BITS-1:0] coeff_reg;
    logic [DLEN_BITS-1:0]  delay_reg;
    logic [CHAN_BITS-1:0]  chan_reg;

    lpl_reg_t reg_sel;
    logic     wr;
    lpl_cfg_t cfg;

    lpl_stream_if #(.T(lpl_job_t)) job_in ();
    lpl_stream_if #(.T(lpl_job_t)) job_out ();

    assign pready  = 1'b1;
    assign reg_sel = lpl_reg_t'(paddr[PADDR_BITS-1:2]);
    assign wr      = psel && penable && pwrite;

    // Register readback
    always_comb
    begin
        case (reg_sel)
            REG_CEILING: prdata = PDATA_BITS'(ceiling_reg);
            REG_COEFF:   prdata = PDATA_BITS'(coeff_reg);
            REG_DELAY:   prdata = PDATA_BITS'(delay_reg);
            REG_CHANNEL: prdata = PDATA_BITS'(chan_reg);
            default:     prdata = '0;
        endcase
    end

    // Drop the ring contents on any delay write, or on a change of channel count
    always_comb
    begin
        cfg.ceiling_level = ceiling_reg;
        cfg.release_coeff = coeff_reg;
        cfg.delay_length  = delay_reg;
        cfg.stereo        = chan_reg[1];
        cfg.clear         = wr && ((reg_sel == REG_DELAY) ||
                                   ((reg_sel == REG_CHANNEL) &&
                                    (pwdata[CHAN_BITS-1:0] != chan_reg)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceiling_reg <= CEIL_RESET;
            coeff_reg   <= COEFF_RESET;
            delay_reg   <= DLEN_RESET;
            chan_reg    <= CHAN_RESET;
        end
        else if (wr)
        begin
            case (reg_sel)
                REG_CEILING: ceiling_reg <= pwdata[CEIL_BITS-1:0];
                REG_COEFF:   coeff_reg   <= pwdata[COEFF_BITS-1:0];
                REG_DELAY:   delay_reg   <= pwdata[DLEN_BITS-1:0];
                REG_CHANNEL: chan_reg    <= pwdata[CHAN_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Front: take the frame, find the peak, divide out the target gain
    lpl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_frame (in_frame),
        .job      (job_in)
    );

    // Hold up to two classified frames
    lpl_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_in),
        .pop   (job_out)
    );

    // Back: advance the envelope, run the delay ring, apply the gain
    lpl_back #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job       (job_out),
        .out_frame (out_frame)
    );

endmodule

`default_nettype wire

// ===== tb/lookahead_peak_limiter_top_tb.sv =====
module lookahead_peak_limiter_top_tb
    import lpl_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DELAY_DEPTH      = 256;
    localparam int unsigned CYCLE_LIMIT      = 1_000_000;
    localparam int          SETTLE_CYCLES    = 40;
    localparam int          SHOWN_MISMATCHES = 40;
    localparam int          RANDOM_PHASES    = 12;
    localparam longint      UNITY_GAIN       = longint'(1) <<< GAIN_FRAC_BITS;
    localparam longint      ROUND_HALF       = longint'(1) <<< (GAIN_FRAC_BITS - 1);

    localparam lpl_sample_t          SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam lpl_sample_t          SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [CEIL_BITS-1:0] CEIL_MAX   = '1;

    // Idle modes: sender gap and receiver stall, in percent
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_TAKE = 2;
    localparam int IDLE_BOTH = 3;

    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    lpl_stream_if #(.T(lpl_in_t))  in_frame ();
    lpl_stream_if #(.T(lpl_out_t)) out_frame ();

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [PDATA_BITS-1:0] pwdata;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    lookahead_peak_limiter_top #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_frame  (in_frame),
        .out_frame (out_frame),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // ------------------------------------------------------------------
    // Limiter state as the block should hold it: registers, gain envelope,
    // the per-channel look-ahead ring and its write pointer.
    // ------------------------------------------------------------------
    logic [CEIL_BITS-1:0]  cfg_ceiling;
    logic [COEFF_BITS-1:0] cfg_coeff;
    logic [DLEN_BITS-1:0]  cfg_delay;
    logic [CHAN_BITS-1:0]  cfg_channels;
    lpl_gain_t             envelope;
    lpl_sample_t           delay_ring [2][DELAY_DEPTH];
    int                    ring_wr;

    lpl_in_t     pending_frames[$];   // requests not yet offered
    lpl_out_t    expected_frames[$];  // limited frames still owed by the block

    int unsigned send_gap_pct;
    int unsigned take_stall_pct;
    int unsigned cycle_count;
    int          mismatch_count;
    int          frames_checked;
    int          settings_used;

    function automatic void clear_ring();
        foreach (delay_ring[c, i])
            delay_ring[c][i] = '0;
        ring_wr = 0;
    endfunction

    // Work out the limited frame for one accepted request and advance the state.
    function automatic lpl_out_t limit_frame(input lpl_in_t f);
        lpl_out_t r;
        longint   s [2];
        longint   scaled [2];
        longint   peak;
        longint   mag;
        longint   target;
        longint   src;
        int       nch;
        int       span;
        int       rd;
        nch = (cfg_channels >= 2) ? 2 : 1;
        s[0] = longint'($signed(f.sample_ch0));
        s[1] = longint'($signed(f.sample_ch1));
        scaled[0] = 0;
        scaled[1] = 0;

        peak = 0;
        for (int c = 0; c < nch; c++)
        begin
            mag = (s[c] < 0) ? -s[c] : s[c];
            if (mag > peak)
                peak = mag;
        end

        if (peak > longint'(cfg_ceiling))
            target = (longint'(cfg_ceiling) <<< GAIN_FRAC_BITS) / peak;
        else
            target = UNITY_GAIN;

        // Attack is instant, release is a one-pole blend toward the target
        if (target < longint'(envelope))
            envelope = lpl_gain_t'(target);
        else
            envelope = lpl_gain_t'((longint'(cfg_coeff) * longint'(envelope)
                        + (UNITY_GAIN - longint'(cfg_coeff)) * target) >>> GAIN_FRAC_BITS);

        span = int'(cfg_delay) + 1;
        if (cfg_delay != 0)
            ring_wr = ring_wr % span;
        for (int c = 0; c < nch; c++)
        begin
            if (cfg_delay != 0)
            begin
                rd = (ring_wr + 1) % span;
                delay_ring[c][ring_wr] = lpl_sample_t'(s[c]);
                src = longint'($signed(delay_ring[c][rd]));
            end
            else
                src = s[c];
            // Round half up: floor((x*g + 2^15) / 2^16)
            scaled[c] = (src * longint'(envelope) + ROUND_HALF) >>> GAIN_FRAC_BITS;
        end
        if (cfg_delay != 0)
            ring_wr = (ring_wr + 1) % span;

        r.out_ch0        = lpl_sample_t'(scaled[0]);
        r.out_ch1        = lpl_sample_t'(scaled[1]);
        r.applied_gain   = envelope;
        r.block_last_out = f.block_last;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: offer pending frames, predict each one as it is taken.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : feed_frames
        if (!rst_n)
        begin
            in_frame.valid   <= 1'b0;
            in_frame.payload <= '0;
        end
        else
        begin
            if (in_frame.valid && in_frame.ready)
                expected_frames.push_back(limit_frame(in_frame.payload));
            // Hold the current request until it is taken, then maybe gap
            if (!in_frame.valid || in_frame.ready)
            begin
                if (pending_frames.size() > 0 && $urandom_range(0, 99) >= send_gap_pct)
                begin
                    in_frame.valid   <= 1'b1;
                    in_frame.payload <= pending_frames.pop_front();
                end
                else
                    in_frame.valid <= 1'b0;
            end
        end
    end

    task automatic report(input string field, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= SHOWN_MISMATCHES)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    // ------------------------------------------------------------------
    // Result monitor: stall at random, check each taken frame in order.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : take_frames
        lpl_out_t want;
        if (!rst_n)
            out_frame.ready <= 1'b0;
        else
        begin
            if (out_frame.valid && out_frame.ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_MISMATCHES)
                        $display("%0t: unexpected frame, expected none, actual %h",
                                 $time, out_frame.payload);
                end
                else
                begin
                    want = expected_frames.pop_front();
                    frames_checked++;
                    if (out_frame.payload.out_ch0 !== want.out_ch0)
                        report("out_ch0", $signed(want.out_ch0),
                               $signed(out_frame.payload.out_ch0));
                    if (out_frame.payload.out_ch1 !== want.out_ch1)
                        report("out_ch1", $signed(want.out_ch1),
                               $signed(out_frame.payload.out_ch1));
                    if (out_frame.payload.applied_gain !== want.applied_gain)
                        report("applied_gain", want.applied_gain,
                               out_frame.payload.applied_gain);
                    if (out_frame.payload.block_last_out !== want.block_last_out)
                        report("block_last_out", want.block_last_out,
                               out_frame.payload.block_last_out);
                end
            end
            out_frame.ready <= ($urandom_range(0, 99) >= take_stall_pct);
        end
    end

    // Drop the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[lookahead_peak_limiter_top] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic set_idle(input int mode);
        case (mode)
            IDLE_NONE: begin send_gap_pct = 0;  take_stall_pct = 0;  end
            IDLE_SEND: begin send_gap_pct = 59; take_stall_pct = 0;  end
            IDLE_TAKE: begin send_gap_pct = 0;  take_stall_pct = 59; end
            IDLE_BOTH: begin send_gap_pct = 21; take_stall_pct = 21; end
            default:   begin send_gap_pct = 0;  take_stall_pct = 0;  end
        endcase
    endtask

    // Advance until every request is taken and every frame is back, then
    // let the block settle before the registers change.
    task automatic wait_drained();
        while (pending_frames.size() != 0 || in_frame.valid || expected_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input lpl_reg_t idx, input logic [PDATA_BITS-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_BITS'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // The access edge has passed: mirror the write
        case (idx)
            REG_CEILING: cfg_ceiling = val[CEIL_BITS-1:0];
            REG_COEFF:   cfg_coeff   = val[COEFF_BITS-1:0];
            REG_DELAY:
            begin
                cfg_delay = val[DLEN_BITS-1:0];
                clear_ring();
            end
            REG_CHANNEL:
            begin
                // Same channel count keeps the ring contents
                if (val[CHAN_BITS-1:0] != cfg_channels)
                    clear_ring();
                cfg_channels = val[CHAN_BITS-1:0];
            end
            default: ;
        endcase
    endtask

    task automatic push_frame(input lpl_sample_t a, input lpl_sample_t b, input logic last);
        pending_frames.push_back('{sample_ch0: a, sample_ch1: b, block_last: last});
    endtask

    // Mix of full-scale, tiny, near-ceiling and fully random samples
    function automatic lpl_sample_t pick_sample();
        longint m;
        case ($urandom_range(0, 7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return lpl_sample_t'(int'($urandom_range(0, 511)) - 256);
            3, 4:
            begin
                m = longint'(cfg_ceiling) + longint'($urandom_range(0, 64)) - 32;
                if (m < 0)
                    m = -m;
                if (m > longint'(SAMPLE_MAX))
                    m = longint'(SAMPLE_MAX);
                if ($urandom_range(0, 1))
                    m = -m;
                return lpl_sample_t'(m);
            end
            default: return lpl_sample_t'($urandom);
        endcase
    endfunction

    // One random register setting followed by a burst of random frames.
    // Extremes rotate with the phase number.
    task automatic random_phase(input int p);
        logic [CEIL_BITS-1:0]  ceil_v;
        logic [COEFF_BITS-1:0] coeff_v;
        logic [DLEN_BITS-1:0]  dlen_v;
        int                    n;
        case (p % 4)
            0:       ceil_v = CEIL_BITS'(1);
            1:       ceil_v = CEIL_MAX;
            2:       ceil_v = CEIL_BITS'($urandom_range(1, 8388607));
            default: ceil_v = CEIL_BITS'($urandom_range(1000, 2000000));
        endcase
        case (p % 3)
            0:       coeff_v = '0;
            1:       coeff_v = '1;
            default: coeff_v = COEFF_BITS'($urandom_range(0, 65535));
        endcase
        n = 100;
        write_reg(REG_CEILING, PDATA_BITS'(ceil_v));
        write_reg(REG_COEFF, PDATA_BITS'(coeff_v));
        // Every fourth setting leaves the delay alone so the ring may carry over
        if (p == 5)
        begin
            dlen_v = '1;
            n = 300;   // long enough to wrap the deepest ring
            write_reg(REG_DELAY, PDATA_BITS'(dlen_v));
        end
        else if (p % 4 != 2)
        begin
            dlen_v = (p == 0) ? DLEN_BITS'(1) : DLEN_BITS'($urandom_range(0, 12));
            write_reg(REG_DELAY, PDATA_BITS'(dlen_v));
        end
        write_reg(REG_CHANNEL, PDATA_BITS'($urandom_range(0, 3)));
        settings_used++;
        set_idle(p % 4);
        repeat (n)
            push_frame(pick_sample(), pick_sample(), 1'($urandom_range(0, 1)));
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        in_frame.valid   = 1'b0;
        in_frame.payload = '0;
        out_frame.ready  = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        cycle_count      = 0;
        mismatch_count   = 0;
        frames_checked   = 0;
        settings_used    = 1;
        cfg_ceiling      = CEIL_RESET;
        cfg_coeff        = COEFF_RESET;
        cfg_delay        = DLEN_RESET;
        cfg_channels     = CHAN_RESET;
        envelope         = GAIN_UNITY;
        clear_ring();
        set_idle(IDLE_NONE);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: stereo, no delay, full-scale ceiling.
        // Negative full scale is the only peak above the ceiling here.
        push_frame('0, '0, 1'b0);
        push_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
        push_frame(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
        push_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
        push_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        push_frame(lpl_sample_t'(1), lpl_sample_t'(-1), 1'b1);
        push_frame(lpl_sample_t'(-1), SAMPLE_MAX, 1'b0);
        wait_drained();

        // Ceiling zero with mono (channel count zero) and a short ring:
        // any nonzero peak mutes, a silent frame releases toward unity,
        // and channel one must neither limit nor appear at the output.
        write_reg(REG_CEILING, '0);
        write_reg(REG_DELAY, PDATA_BITS'(2));
        write_reg(REG_CHANNEL, '0);
        settings_used++;
        push_frame('0, SAMPLE_MAX, 1'b0);
        push_frame(lpl_sample_t'(5), '0, 1'b1);
        push_frame('0, SAMPLE_MIN, 1'b0);
        push_frame(lpl_sample_t'(-5), lpl_sample_t'(7), 1'b0);
        push_frame(SAMPLE_MIN, '0, 1'b1);
        push_frame('0, '0, 1'b0);
        wait_drained();

        // Channel count three acts as stereo; instant release with zero
        // coefficient; half gain exercises the round-half-up ties.
        write_reg(REG_CEILING, PDATA_BITS'(4096));
        write_reg(REG_COEFF, '0);
        write_reg(REG_DELAY, '0);
        write_reg(REG_CHANNEL, PDATA_BITS'(3));
        settings_used++;
        push_frame(lpl_sample_t'(3), lpl_sample_t'(-8192), 1'b0);
        push_frame(lpl_sample_t'(-3), lpl_sample_t'(8192), 1'b1);
        push_frame(lpl_sample_t'(1), lpl_sample_t'(-8192), 1'b0);
        push_frame(lpl_sample_t'(-1), lpl_sample_t'(8192), 1'b0);
        push_frame(lpl_sample_t'(2), lpl_sample_t'(-1), 1'b1);
        wait_drained();

        // Slowest release, one-frame look-ahead, mono with channel count one
        write_reg(REG_CEILING, PDATA_BITS'(CEIL_MAX));
        write_reg(REG_COEFF, PDATA_BITS'(16'hFFFF));
        write_reg(REG_DELAY, PDATA_BITS'(1));
        write_reg(REG_CHANNEL, PDATA_BITS'(1));
        settings_used++;
        push_frame(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
        push_frame(SAMPLE_MAX, lpl_sample_t'(-1), 1'b1);
        push_frame(lpl_sample_t'(100), SAMPLE_MAX, 1'b0);
        push_frame('0, '0, 1'b1);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++)
            random_phase(p);

        $display("Checked %0d limited frames over %0d register settings,", frames_checked,
                 settings_used);
        $display("mono and stereo, ceilings zero to full scale, look-ahead up to 255 frames.");
        if (mismatch_count == 0)
            $display("[lookahead_peak_limiter_top] OK");
        else
            $display("[lookahead_peak_limiter_top] ERROR");
        $finish;
    end

endmodule
